@@ rtl/p2f_pkg.sv @@
// Package: sample format codes and conversion helper functions.
`timescale 1ns / 1ps
package p2f_pkg;

   typedef enum logic [2:0] {
      FMT_F32 = 3'd0,
      FMT_F64 = 3'd1,
      FMT_S8  = 3'd2,
      FMT_U8  = 3'd3,
      FMT_S16 = 3'd4,
      FMT_S24 = 3'd5,
      FMT_S32 = 3'd6,
      FMT_DSD = 3'd7
   } fmt_type;

   localparam logic [31:0] F32_INF   = 32'h7F80_0000;
   localparam logic [31:0] F32_QNAN  = 32'h7FC0_0000;

   // Round-to-nearest-even increment for a kept lsb, guard and sticky.
   function automatic logic rne_inc(input logic lsb, input logic guard, input logic sticky);
      rne_inc = guard & (sticky | lsb);
   endfunction

endpackage

@@ rtl/p2f_int_conv.sv @@
// Module: signed magnitude integer (magnitude below 2^33) to float32 with scaling.
`timescale 1ns / 1ps
module p2f_int_conv
   import p2f_pkg::*;
(
   input  logic        neg,
   input  logic [32:0] mag,
   input  logic [4:0]  scale_k,
   output logic [31:0] float_bits
);
   logic [5:0]  msb;
   logic [32:0] norm;
   logic [23:0] keep;
   logic        guard;
   logic        sticky;
   logic [24:0] rnd;
   logic [7:0]  bexp;

   // Locate the leading one.
   always_comb begin
      msb = 6'd0;
      for (int i = 0; i < 33; i++) begin
         if (mag[i]) begin
            msb = 6'(i);
         end
      end
   end

   // Left-align the leading one at bit 32.
   assign norm   = mag << (6'd32 - msb);
   assign keep   = norm[32:9];
   assign guard  = norm[8];
   assign sticky = |norm[7:0];
   assign rnd    = {1'b0, keep} + {24'd0, rne_inc(keep[0], guard, sticky)};

   always_comb begin
      bexp = 8'(msb) + 8'd127 - {3'd0, scale_k} + {7'd0, rnd[24]};
      if (mag == 33'd0) begin
         float_bits = 32'd0;
      end else begin
         float_bits = {neg, bexp, (rnd[24] ? rnd[23:1] : rnd[22:0])};
      end
   end
endmodule

@@ rtl/p2f_f64_conv.sv @@
// Module: float64 to float32 narrowing with round to nearest even.
`timescale 1ns / 1ps
module p2f_f64_conv
   import p2f_pkg::*;
(
   input  logic [63:0] dbl,
   output logic [31:0] float_bits
);
   logic        sgn;
   logic [10:0] e;
   logic [51:0] m;
   logic [52:0] sig;
   logic signed [12:0] fe;
   logic [23:0] nkeep;
   logic [24:0] nrnd;
   logic [5:0]  sh;
   logic [52:0] shifted;
   logic [23:0] skeep;
   logic [52:0] below_mask;
   logic        sub_sticky;
   logic        sub_guard;
   logic [23:0] sub_keep;

   assign sgn = dbl[63];
   assign e   = dbl[62:52];
   assign m   = dbl[51:0];
   assign sig = {1'b1, m};
   assign fe  = $signed({2'b00, e}) - 13'sd896;

   // Normal path: drop 29 bits.
   assign nkeep = sig[52:29];
   assign nrnd  = {1'b0, nkeep} + {24'd0, rne_inc(sig[29], sig[28], |sig[27:0])};

   // Subnormal path: shift by 29 - fe (29..52), keep guard at bit 0.
   assign sh      = 6'(13'sd30 - fe - 13'sd1);
   assign shifted = sig >> sh;

   assign below_mask = (53'd1 << sh) - 53'd1;
   assign sub_guard  = shifted[0];
   assign sub_sticky = |(sig & below_mask);
   assign sub_keep   = shifted[24:1];
   assign skeep      = sub_keep + {23'd0, rne_inc(sub_keep[0], sub_guard, sub_sticky)};

   always_comb begin
      if (e == 11'h7FF) begin
         float_bits = (m == 52'd0) ? ({sgn, 31'd0} | F32_INF)
                                   : ({sgn, 31'd0} | F32_QNAN | {10'd0, m[50:29]});
      end else if (e == 11'd0) begin
         float_bits = {sgn, 31'd0};
      end else if (fe >= 13'sd255) begin
         float_bits = {sgn, 31'd0} | F32_INF;
      end else if (fe >= 13'sd1) begin
         if (nrnd[24]) begin
            float_bits = (fe >= 13'sd254) ? ({sgn, 31'd0} | F32_INF)
                                          : {sgn, 8'(fe + 13'sd1), 23'd0};
         end else begin
            float_bits = {sgn, fe[7:0], nrnd[22:0]};
         end
      end else if (fe < -13'sd23) begin
         float_bits = {sgn, 31'd0};
      end else begin
         float_bits = {sgn, 7'd0, skeep};
      end
   end
endmodule

@@ rtl/pcm_to_float32_converter.sv @@
// Top level: PCM / float64 sample to float32 converter with register slices.
`timescale 1ns / 1ps
//  channel | direction | ports                              | moves
//  req     | in        | req_valid req_ready req_raw_sample | one raw sample word
//  rsp     | out       | rsp_valid rsp_ready rsp_float_bits | one float32 word
//          |           | rsp_unsupported                    |
//  csr     | in        | csr_valid csr_ready csr_sample_format | format register write
//
//  Samples pass an input register, then a result register, with combinational
//  conversion between them. One word per cycle is sustained while rsp_ready is high.
//  Reset clears the valid flags and the format register (float32 pass-through).
//  A stalled result holds in the result register; the input register advances
//  whenever the result register is free or drains in the same cycle.
module pcm_to_float32_converter
   import p2f_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_raw_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_float_bits,
   output logic        rsp_unsupported,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_sample_format
);
   fmt_type     fmt_ff, fmt_in;
   logic        in_vld_ff, in_vld_in;
   logic [63:0] in_raw_ff, in_raw_in;
   logic        out_vld_ff, out_vld_in;
   logic [31:0] out_bits_ff, out_bits_in;
   logic        out_uns_ff, out_uns_in;

   logic        adv;
   logic        int_neg;
   logic [32:0] int_mag;
   logic [4:0]  int_k;
   logic [31:0] int_bits;
   logic [31:0] dbl_bits;

   assign csr_ready = 1'b1;
   // Advance the input stage when the result register is empty or draining.
   assign adv       = ~out_vld_ff | rsp_ready;
   assign req_ready = ~in_vld_ff | adv;

   assign fmt_in    = (csr_valid) ? fmt_type'(csr_sample_format) : fmt_ff;
   assign in_vld_in = req_ready ? req_valid : in_vld_ff;
   assign in_raw_in = (req_valid && req_ready) ? req_raw_sample : in_raw_ff;

   // Form sign and magnitude for the integer formats.
   always_comb begin
      int_neg = 1'b0;
      int_mag = 33'd0;
      int_k   = 5'd0;
      unique case (fmt_ff)
         FMT_S8: begin
            int_neg = in_raw_ff[7];
            int_mag = in_raw_ff[7] ? 33'h100 - {25'd0, in_raw_ff[7:0]} : {25'd0, in_raw_ff[7:0]};
            int_k   = 5'd7;
         end
         FMT_U8: begin
            int_neg = ~in_raw_ff[7];
            int_mag = in_raw_ff[7] ? {26'd0, in_raw_ff[6:0]}
                                   : 33'h80 - {25'd0, in_raw_ff[7:0]};
            int_k   = 5'd7;
         end
         FMT_S16: begin
            int_neg = in_raw_ff[15];
            int_mag = in_raw_ff[15] ? 33'h10000 - {17'd0, in_raw_ff[15:0]}
                                    : {17'd0, in_raw_ff[15:0]};
            int_k   = 5'd15;
         end
         FMT_S24: begin
            int_neg = in_raw_ff[23];
            int_mag = in_raw_ff[23] ? 33'h1000000 - {9'd0, in_raw_ff[23:0]}
                                    : {9'd0, in_raw_ff[23:0]};
            int_k   = 5'd23;
         end
         FMT_S32: begin
            int_neg = in_raw_ff[31];
            int_mag = in_raw_ff[31] ? 33'h1_0000_0000 - {1'b0, in_raw_ff[31:0]}
                                    : {1'b0, in_raw_ff[31:0]};
            int_k   = 5'd31;
         end
         default: begin
            int_neg = 1'b0;
            int_mag = 33'd0;
            int_k   = 5'd0;
         end
      endcase
   end

   p2f_int_conv u_int (
      .neg        (int_neg),
      .mag        (int_mag),
      .scale_k    (int_k),
      .float_bits (int_bits)
   );

   p2f_f64_conv u_f64 (
      .dbl        (in_raw_ff),
      .float_bits (dbl_bits)
   );

   // Pick the result for the active format; hold while stalled.
   always_comb begin
      out_vld_in  = adv ? in_vld_ff : out_vld_ff;
      out_bits_in = out_bits_ff;
      out_uns_in  = out_uns_ff;
      if (adv && in_vld_ff) begin
         out_uns_in = 1'b0;
         unique case (fmt_ff)
            FMT_F32: out_bits_in = in_raw_ff[31:0];
            FMT_F64: out_bits_in = dbl_bits;
            FMT_DSD: begin
               out_bits_in = 32'd0;
               out_uns_in  = 1'b1;
            end
            default: out_bits_in = int_bits;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= FMT_F32;
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         fmt_ff     <= fmt_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_raw_ff   <= in_raw_in;
      out_bits_ff <= out_bits_in;
      out_uns_ff  <= out_uns_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_float_bits  = out_bits_ff;
   assign rsp_unsupported = out_uns_ff;
endmodule

@@ dv/testbench.sv @@
// Testbench for the PCM / float64 to float32 converter with a self-checking scoreboard.
`timescale 1ns / 1ps

module testbench
   import p2f_pkg::*;
;

   // Expected float32 word for one raw sample under a given format.
   typedef struct packed {
      logic [31:0] float_bits;
      logic        unsupported;
   } float_word_type;

   // Shift right and round to nearest, ties to even.
   function automatic logic [63:0] shift_rne(input logic [63:0] sig, input int sh);
      logic [63:0] keep;
      logic [63:0] rem;
      logic [63:0] half;
      keep = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
      return keep;
   endfunction

   // Float32 bits of +/- mag * 2^-k.
   function automatic logic [31:0] scale_int(input logic neg, input logic [63:0] mag,
                                             input int k);
      int          msb;
      logic [63:0] keep;
      logic [31:0] bexp;
      if (mag == 64'd0) return 32'd0;
      msb = 0;
      while (msb < 63 && (mag >> (msb + 1)) != 64'd0) msb++;
      if (msb <= 23) begin
         keep = mag << (23 - msb);
      end else begin
         keep = shift_rne(mag, msb - 23);
         if (keep == (64'd1 << 24)) begin
            keep = keep >> 1;
            msb++;
         end
      end
      bexp = 32'(msb + 127 - k);
      return {neg, 31'd0} | (bexp << 23) | {9'd0, keep[22:0]};
   endfunction

   function automatic logic [31:0] narrow_double(input logic [63:0] d);
      logic [31:0] sgn;
      int          e;
      int          fe;
      logic [51:0] m;
      logic [63:0] sig;
      logic [63:0] keep;
      sgn = {d[63], 31'd0};
      e   = int'(d[62:52]);
      m   = d[51:0];
      if (e == 2047) begin
         if (m == 52'd0) return sgn | F32_INF;
         return sgn | F32_QNAN | {10'd0, m[50:29]};
      end
      if (e == 0) return sgn;
      sig = {11'd0, 1'b1, m};
      fe  = e - 1023 + 127;
      if (fe >= 255) return sgn | F32_INF;
      if (fe >= 1) begin
         keep = shift_rne(sig, 29);
         if (keep == (64'd1 << 24)) begin
            keep = keep >> 1;
            fe++;
            if (fe >= 255) return sgn | F32_INF;
         end
         return sgn | (32'(fe) << 23) | {9'd0, keep[22:0]};
      end
      if (fe < -23) return sgn;
      keep = shift_rne(sig, 30 - fe);
      return sgn | keep[31:0];
   endfunction

   function automatic float_word_type convert_sample(input fmt_type fmt, input logic [63:0] raw);
      float_word_type w;
      w.float_bits  = 32'd0;
      w.unsupported = 1'b0;
      case (fmt)
         FMT_F32: w.float_bits = raw[31:0];
         FMT_F64: w.float_bits = narrow_double(raw);
         FMT_S8: w.float_bits = raw[7] ? scale_int(1'b1, 64'h100 - raw[7:0], 7)
                                       : scale_int(1'b0, 64'(raw[7:0]), 7);
         FMT_U8: w.float_bits = !raw[7] ? scale_int(1'b1, 64'h80 - raw[7:0], 7)
                                        : scale_int(1'b0, 64'(raw[7:0]) - 64'h80, 7);
         FMT_S16: w.float_bits = raw[15] ? scale_int(1'b1, 64'h10000 - raw[15:0], 15)
                                         : scale_int(1'b0, 64'(raw[15:0]), 15);
         FMT_S24: w.float_bits = raw[23] ? scale_int(1'b1, 64'h1000000 - raw[23:0], 23)
                                         : scale_int(1'b0, 64'(raw[23:0]), 23);
         FMT_S32: w.float_bits = raw[31] ? scale_int(1'b1, 64'h100000000 - raw[31:0], 31)
                                         : scale_int(1'b0, 64'(raw[31:0]), 31);
         default: begin
            w.unsupported = 1'b1;
         end
      endcase
      return w;
   endfunction

   class float_scoreboard;
      float_word_type pending[$];
      fmt_type        fmt;
      int             mismatches;

      function new();
         fmt = FMT_F32;
         mismatches = 0;
      endfunction

      function void note_sample(input logic [63:0] raw);
         pending.push_back(convert_sample(fmt, raw));
      endfunction

      function void check_word(input logic [31:0] bits, input logic unsup);
         float_word_type exp_w;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h/%b", bits, unsup);
            return;
         end
         exp_w = pending.pop_front();
         if (exp_w.float_bits !== bits || exp_w.unsupported !== unsup) begin
            mismatches++;
            if (mismatches <= 10)
               $display("word mismatch: expected %h/%b actual %h/%b",
                        exp_w.float_bits, exp_w.unsupported, bits, unsup);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_raw_sample = 64'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_float_bits;
   logic        rsp_unsupported;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_sample_format = 3'd0;

   float_scoreboard scoreboard = new();
   bit              calm = 1'b0;   // no idling in the last stretch

   always #6 clock = ~clock;

   pcm_to_float32_converter i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_raw_sample(req_raw_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_float_bits(rsp_float_bits),
      .rsp_unsupported(rsp_unsupported),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_sample_format(csr_sample_format)
   );

   // Check every accepted result word at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) scoreboard.check_word(rsp_float_bits, rsp_unsupported);
   end

   // Receiver: stall in random bursts, never during the calm stretch.
   initial begin
      int burst;
      @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
         if (!calm && $urandom_range(0, 1)) begin
            burst = $urandom_range(1, 7);
            rsp_ready <= 1'b0;
            repeat (burst) @(negedge clock);
         end
      end
   end

   // Hand one sample word over; hold valid and payload until accepted.
   task automatic send_sample(input logic [63:0] raw);
      req_valid      <= 1'b1;
      req_raw_sample <= raw;
      do @(posedge clock); while (!req_ready);
      scoreboard.note_sample(raw);
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
   endtask

   // Drain all expected words, let the pipeline settle, then write the format.
   task automatic write_format(input fmt_type fmt);
      req_valid <= 1'b0;
      while (scoreboard.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid         <= 1'b1;
      csr_sample_format <= fmt;
      do @(posedge clock); while (!csr_ready);
      scoreboard.fmt = fmt;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random sample biased toward extremes and the format's special values.
   function automatic logic [63:0] pick_sample(input fmt_type fmt);
      logic [63:0] r;
      r = {$urandom, $urandom};
      if (fmt == FMT_F64) begin
         case ($urandom_range(0, 7))
            0: r[62:52] = 11'h7FF;
            1: r[62:52] = 11'd0;
            2: r[62:52] = 11'(1023 - 127 - $urandom_range(0, 26));
            3: r[62:52] = 11'(1023 + 127 + $urandom_range(0, 1));
            4: r[28:0]  = 29'h1000_0000;
            5: r[51:29] = '1;
            default: r[62:52] = 11'(1023 + $urandom_range(0, 250) - 125);
         endcase
      end else if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: r[31:0] = 32'h8000_0000;
            1: r[31:0] = 32'h7FFF_FFFF;
            2: r[31:0] = 32'd0;
            default: r[31:0] = 32'hFFFF_FF80 | 32'($urandom_range(0, 127));
         endcase
      end
      return r;
   endfunction

   initial begin
      logic [63:0] directed [$];
      fmt_type     fmt;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: one extreme set per format.
      directed = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0080,
                   64'h0000_0000_0000_007F, 64'h0000_0000_8000_0000};
      for (int f = 0; f < 8; f++) begin
         write_format(fmt_type'(f));
         foreach (directed[i]) send_sample(directed[i]);
      end
      // Double special cases: infinity, NaN, overflow, subnormal rounding, tie.
      write_format(FMT_F64);
      send_sample(64'h7FF0_0000_0000_0000);
      send_sample(64'hFFF0_0000_0000_0001);
      send_sample(64'h47EF_FFFF_F000_0000);
      send_sample(64'h3690_0000_0000_0000);
      send_sample(64'h3810_0000_1000_0000);
      send_sample(64'h0000_0000_0000_0001);
      // Signed 32 rounding ties.
      write_format(FMT_S32);
      send_sample(64'h0000_0000_0100_0001);
      send_sample(64'h0000_0000_7FFF_FFC0);
      send_sample(64'h0000_0000_0300_0002);

      // Random phases with a format write between them.
      for (int phase = 0; phase < 15; phase++) begin
         fmt = (phase == 0) ? FMT_F32 : (phase == 14) ? FMT_DSD
                                      : fmt_type'($urandom_range(0, 7));
         if (phase == 12) calm = 1'b1;
         write_format(fmt);
         for (int n = 0; n < 100; n++) send_sample(pick_sample(fmt));
      end

      req_valid <= 1'b0;
      while (scoreboard.pending.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (scoreboard.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/p2f_pkg.sv
rtl/p2f_int_conv.sv
rtl/p2f_f64_conv.sv
rtl/pcm_to_float32_converter.sv
dv/testbench.sv
